>>> design/bmg_pkg.sv
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared constants and types for the Box-Muller gaussian generator.
// ----------------------------------------------------------------------------
package bmg_pkg;

    localparam int WF = 56;
    localparam int UNIFORM_BITS_DEF = 32;
    localparam int OUT_FRAC_BITS = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [63:0] ONE_W = 64'd1 << WF;
    localparam logic [63:0] PI2_W = 64'h06487ED5110B4612;
    localparam logic [63:0] LN2_W = 64'h00B17217F7D1CF7A;
    localparam logic [63:0] HALF_LSB_W = 64'd1 << (WF - 1);

    localparam int ATANH_TERMS = 20;
    localparam int TRIG_TERMS = 12;
    localparam int NEWTON_ITERS = 8;
    localparam int LOG_DIV_QB = 56;
    localparam int ROOT_DIV_QB = 60;

    localparam logic [DATA_W-1:0] MEAN_RESET = '0;
    localparam logic [DATA_W-1:0] SIGMA_RESET = DATA_W'(1) << OUT_FRAC_BITS;

    typedef enum logic {
        REG_MEAN  = 1'b0,
        REG_SIGMA = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] mean;
        logic [DATA_W-1:0] sigma;
    } cfg_t;

endpackage

>>> design/bmg_uniform_if.sv
// ----------------------------------------------------------------------------
// bmg_uniform_if
// Request channel carrying a pair of uniform variates.
// ----------------------------------------------------------------------------
interface bmg_uniform_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] u_radius;
    logic [W-1:0] u_angle;

    modport source (output valid, output u_radius, output u_angle, input ready);
    modport sink   (input valid, input u_radius, input u_angle, output ready);
endinterface

>>> design/bmg_gauss_if.sv
// ----------------------------------------------------------------------------
// bmg_gauss_if
// Result channel carrying one gaussian sample and its saturation flag.
// ----------------------------------------------------------------------------
interface bmg_gauss_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               clipped;

    modport source (output valid, output sample, output clipped, input ready);
    modport sink   (input valid, input sample, input clipped, output ready);
endinterface

>>> design/bmg_mulq.sv
// ----------------------------------------------------------------------------
// bmg_mulq
// Two-stage Q8.56 multiplier: 32x32 partial products, then sum and truncate.
// ----------------------------------------------------------------------------
module bmg_mulq
    import bmg_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [63:0]       p,
    output logic [SIDE_W-1:0] side_out
);

    logic [63:0]       ll_reg, lh_reg, hl_reg, hh_reg;
    logic [SIDE_W-1:0] s1_reg, s2_reg;
    logic              v1_reg, v2_reg;
    logic [63:0]       p_reg;
    logic [127:0]      full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign full = {hh_reg, 64'd0}
                + {32'd0, lh_reg, 32'd0}
                + {32'd0, hl_reg, 32'd0}
                + {64'd0, ll_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            lh_reg <= 64'(a[31:0]) * 64'(b[63:32]);
            hl_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            hh_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            s1_reg <= side_in;
            p_reg  <= full[WF+63:WF];
            s2_reg <= s1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign p         = p_reg;
    assign side_out  = s2_reg;

endmodule

>>> design/bmg_divq.sv
// ----------------------------------------------------------------------------
// bmg_divq
// Pipelined restoring divider, one quotient bit per stage: floor(a*2^56/b).
// ----------------------------------------------------------------------------
module bmg_divq
    import bmg_pkg::*;
#(
    parameter int QB     = 56,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [63:0]       q,
    output logic [SIDE_W-1:0] side_out
);

    logic [63:0]       r_reg [QB];
    logic [63:0]       q_reg [QB];
    logic [63:0]       b_reg [QB];
    logic [63:0]       a_reg [QB];
    logic [SIDE_W-1:0] s_reg [QB];
    logic [QB-1:0]     v_reg;

    for (genvar i = 0; i < QB; i++)
    begin : g_st
        localparam int J = QB - 1 - i;
        logic [63:0]       r_cur, q_cur, b_cur, a_cur;
        logic [SIDE_W-1:0] s_cur;
        logic              v_cur;
        logic              nb;
        logic [64:0]       r2;
        logic              ge;

        if (i == 0)
        begin : g_in
            assign r_cur = a >> (QB - WF);
            assign q_cur = '0;
            assign b_cur = b;
            assign a_cur = a;
            assign s_cur = side_in;
            assign v_cur = in_valid;
        end
        else
        begin : g_mid
            assign r_cur = r_reg[i-1];
            assign q_cur = q_reg[i-1];
            assign b_cur = b_reg[i-1];
            assign a_cur = a_reg[i-1];
            assign s_cur = s_reg[i-1];
            assign v_cur = v_reg[i-1];
        end

        if (J >= WF)
        begin : g_abit
            assign nb = a_cur[J-WF];
        end
        else
        begin : g_zbit
            assign nb = 1'b0;
        end

        assign r2 = {r_cur, nb};
        assign ge = (r2 >= {1'b0, b_cur});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i] <= ge ? 64'(r2 - {1'b0, b_cur}) : r2[63:0];
                q_reg[i] <= {q_cur[62:0], ge};
                b_reg[i] <= b_cur;
                a_reg[i] <= a_cur;
                s_reg[i] <= s_cur;
            end
        end
    end

    assign out_valid = v_reg[QB-1];
    assign q         = q_reg[QB-1];
    assign side_out  = s_reg[QB-1];

endmodule

>>> design/bmg_radius.sv
// ----------------------------------------------------------------------------
// bmg_radius
// Radius path: sqrt(-2 ln u) by atanh series log and unrolled Newton root.
// ----------------------------------------------------------------------------
module bmg_radius
    import bmg_pkg::*;
#(
    parameter int UB     = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [UB-1:0]     k0,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [63:0]       r,
    output logic [SIDE_W-1:0] side_out
);

    localparam int SW_D = 7 + SIDE_W;
    localparam int SW_T = 64 + 64 + 7 + SIDE_W;
    localparam int SW_N = 64 + 64 + 1 + SIDE_W;

    function automatic logic [5:0] top_bit(input logic [63:0] v);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                pos = 6'(i);
        end
        return pos;
    endfunction

    // log argument setup
    logic [UB-1:0]     km;
    logic [63:0]       kx;
    logic [5:0]        ke;
    logic [63:0]       kbase;
    logic [63:0]       la_reg, lb_reg;
    logic [6:0]        ln_reg;
    logic [SIDE_W-1:0] ls_reg;
    logic              lv_reg;

    assign km    = (k0 == '0) ? UB'(1) : k0;
    assign kx    = 64'(km);
    assign ke    = top_bit(kx);
    assign kbase = 64'd1 << ke;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lv_reg <= 1'b0;
        else if (en)
            lv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la_reg <= kx - kbase;
            lb_reg <= kx + kbase;
            ln_reg <= 7'(UB) - {1'b0, ke};
            ls_reg <= side_in;
        end
    end

    // s = (m-1)/(m+1)
    logic              dv;
    logic [63:0]       ds;
    logic [SW_D-1:0]   dside;

    bmg_divq #(.QB(LOG_DIV_QB), .SIDE_W(SW_D)) u_logdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (lv_reg),
        .a        (la_reg),
        .b        (lb_reg),
        .side_in  ({ln_reg, ls_reg}),
        .out_valid(dv),
        .q        (ds),
        .side_out (dside)
    );

    logic              sqv;
    logic [63:0]       s2;
    logic [64+SW_D-1:0] sqside;

    bmg_mulq #(.SIDE_W(64 + SW_D)) u_ssq (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (dv),
        .a        (ds),
        .b        (ds),
        .side_in  ({ds, dside}),
        .out_valid(sqv),
        .p        (s2),
        .side_out (sqside)
    );

    // atanh series terms
    logic [63:0]       t_w   [ATANH_TERMS+1];
    logic [63:0]       sum_w [ATANH_TERMS+1];
    logic [63:0]       s2_w  [ATANH_TERMS+1];
    logic [6:0]        n_w   [ATANH_TERMS+1];
    logic [SIDE_W-1:0] sd_w  [ATANH_TERMS+1];
    logic              v_w   [ATANH_TERMS+1];

    assign t_w[0]   = sqside[64+SW_D-1:SW_D];
    assign sum_w[0] = '0;
    assign s2_w[0]  = s2;
    assign n_w[0]   = sqside[SW_D-1:SIDE_W];
    assign sd_w[0]  = sqside[SIDE_W-1:0];
    assign v_w[0]   = sqv;

    for (genvar i = 0; i < ATANH_TERMS; i++)
    begin : g_term
        localparam logic [63:0] DIV = 64'(2 * i + 1);
        logic [63:0]       sum_reg, t_reg, s2_reg;
        logic [6:0]        n_reg;
        logic [SIDE_W-1:0] sd_reg;
        logic              v_reg;
        logic [SW_T-1:0]   mside;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= v_w[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sum_reg <= sum_w[i] + t_w[i] / DIV;
                t_reg   <= t_w[i];
                s2_reg  <= s2_w[i];
                n_reg   <= n_w[i];
                sd_reg  <= sd_w[i];
            end
        end

        bmg_mulq #(.SIDE_W(SW_T)) u_tmul (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v_reg),
            .a        (t_reg),
            .b        (s2_reg),
            .side_in  ({sum_reg, s2_reg, n_reg, sd_reg}),
            .out_valid(v_w[i+1]),
            .p        (t_w[i+1]),
            .side_out (mside)
        );

        assign sum_w[i+1] = mside[SW_T-1:SW_T-64];
        assign s2_w[i+1]  = mside[SW_T-65:SW_T-128];
        assign n_w[i+1]   = mside[SIDE_W+6:SIDE_W];
        assign sd_w[i+1]  = mside[SIDE_W-1:0];
    end

    // -2 ln u
    logic [63:0]       rv_reg;
    logic [SIDE_W-1:0] rs_reg;
    logic              rvv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvv_reg <= 1'b0;
        else if (en)
            rvv_reg <= v_w[ATANH_TERMS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rv_reg <= (64'(n_w[ATANH_TERMS]) * LN2_W - (sum_w[ATANH_TERMS] << 1)) << 1;
            rs_reg <= sd_w[ATANH_TERMS];
        end
    end

    // Newton seed
    logic [5:0]         vt;
    logic signed [7:0]  tt;
    logic signed [7:0]  te;
    logic [6:0]         sh;

    assign vt = top_bit(rv_reg);
    assign tt = $signed({2'b00, vt}) + 8'sd1 - 8'(WF);
    assign te = (tt + 8'sd1) >>> 1;
    assign sh = 7'(8'(WF) + te);

    logic [63:0]       xv_w [NEWTON_ITERS+1];
    logic [63:0]       xx_w [NEWTON_ITERS+1];
    logic              xd_w [NEWTON_ITERS+1];
    logic [SIDE_W-1:0] xs_w [NEWTON_ITERS+1];
    logic              xvl_w [NEWTON_ITERS+1];

    logic [63:0]       x0v_reg, x0x_reg;
    logic              x0d_reg;
    logic [SIDE_W-1:0] x0s_reg;
    logic              x0vl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x0vl_reg <= 1'b0;
        else if (en)
            x0vl_reg <= rvv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0v_reg <= rv_reg;
            x0x_reg <= (rv_reg == '0) ? 64'd0 : (64'd1 << sh);
            x0d_reg <= (rv_reg == '0);
            x0s_reg <= rs_reg;
        end
    end

    assign xv_w[0]  = x0v_reg;
    assign xx_w[0]  = x0x_reg;
    assign xd_w[0]  = x0d_reg;
    assign xs_w[0]  = x0s_reg;
    assign xvl_w[0] = x0vl_reg;

    for (genvar j = 0; j < NEWTON_ITERS; j++)
    begin : g_newton
        logic              qv;
        logic [63:0]       qq;
        logic [SW_N-1:0]   qside;
        logic [63:0]       qvv, qx;
        logic              qd;
        logic [64:0]       ysum;
        logic [63:0]       y;
        logic [63:0]       nv_reg, nx_reg;
        logic              nd_reg;
        logic [SIDE_W-1:0] ns_reg;
        logic              nvl_reg;

        bmg_divq #(.QB(ROOT_DIV_QB), .SIDE_W(SW_N)) u_rdiv (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (xvl_w[j]),
            .a        (xv_w[j]),
            .b        (xx_w[j]),
            .side_in  ({xv_w[j], xx_w[j], xd_w[j], xs_w[j]}),
            .out_valid(qv),
            .q        (qq),
            .side_out (qside)
        );

        assign qvv  = qside[SW_N-1:SW_N-64];
        assign qx   = qside[SW_N-65:SW_N-128];
        assign qd   = qside[SIDE_W];
        assign ysum = {1'b0, qx} + {1'b0, qq};
        assign y    = ysum[64:1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                nvl_reg <= 1'b0;
            else if (en)
                nvl_reg <= qv;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nv_reg <= qvv;
                ns_reg <= qside[SIDE_W-1:0];
                if (qd || (y >= qx))
                begin
                    nx_reg <= qx;
                    nd_reg <= 1'b1;
                end
                else
                begin
                    nx_reg <= y;
                    nd_reg <= 1'b0;
                end
            end
        end

        assign xv_w[j+1]  = nv_reg;
        assign xx_w[j+1]  = nx_reg;
        assign xd_w[j+1]  = nd_reg;
        assign xs_w[j+1]  = ns_reg;
        assign xvl_w[j+1] = nvl_reg;
    end

    assign out_valid = xvl_w[NEWTON_ITERS];
    assign r         = xx_w[NEWTON_ITERS];
    assign side_out  = xs_w[NEWTON_ITERS];

endmodule

>>> design/bmg_cosine.sv
// ----------------------------------------------------------------------------
// bmg_cosine
// Angle path: octant fold of a turn fraction, then unrolled Taylor series.
// ----------------------------------------------------------------------------
module bmg_cosine
    import bmg_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [WF-1:0]     turn,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [63:0]       cmag,
    output logic              cneg,
    output logic [SIDE_W-1:0] side_out
);

    localparam int SW_A = 2 + SIDE_W;
    localparam int SW_X = 64 + SW_A;
    localparam int SW_S = 64 + 64 + 64 + SW_A;

    // fold
    logic [1:0]      quad;
    logic [WF-3:0]   frac;
    logic            low;
    logic [WF-2:0]   g;
    logic [WF-2:0]   g_reg;
    logic            uc_reg, ng_reg;
    logic [SIDE_W-1:0] s0_reg;
    logic            v0_reg;

    assign quad = turn[WF-1:WF-2];
    assign frac = turn[WF-3:0];
    assign low  = !frac[WF-3];
    assign g    = low ? (WF-1)'(frac) : ((WF-1)'(1) << (WF-2)) - (WF-1)'(frac);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg  <= g;
            uc_reg <= (quad[0] == 1'b0) == low;
            ng_reg <= quad[0] ^ quad[1];
            s0_reg <= side_in;
        end
    end

    logic            xv;
    logic [63:0]     x;
    logic [SW_A-1:0] xside;

    bmg_mulq #(.SIDE_W(SW_A)) u_xmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v0_reg),
        .a        (PI2_W),
        .b        (64'(g_reg)),
        .side_in  ({uc_reg, ng_reg, s0_reg}),
        .out_valid(xv),
        .p        (x),
        .side_out (xside)
    );

    logic            x2v;
    logic [63:0]     x2;
    logic [SW_X-1:0] x2side;

    bmg_mulq #(.SIDE_W(SW_X)) u_x2mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (xv),
        .a        (x),
        .b        (x),
        .side_in  ({x, xside}),
        .out_valid(x2v),
        .p        (x2),
        .side_out (x2side)
    );

    logic [63:0]        tc_w [TRIG_TERMS+1];
    logic [63:0]        ts_w [TRIG_TERMS+1];
    logic signed [63:0] sc_w [TRIG_TERMS+1];
    logic signed [63:0] ss_w [TRIG_TERMS+1];
    logic [63:0]        x2_w [TRIG_TERMS+1];
    logic [SW_A-1:0]    a_w  [TRIG_TERMS+1];
    logic               v_w  [TRIG_TERMS+1];

    assign tc_w[0] = ONE_W;
    assign sc_w[0] = $signed(ONE_W);
    assign ts_w[0] = x2side[SW_X-1:SW_A];
    assign ss_w[0] = $signed(x2side[SW_X-1:SW_A]);
    assign x2_w[0] = x2;
    assign a_w[0]  = x2side[SW_A-1:0];
    assign v_w[0]  = x2v;

    for (genvar k = 0; k < TRIG_TERMS; k++)
    begin : g_term
        localparam logic [63:0] DC = 64'((2 * k + 1) * (2 * k + 2));
        localparam logic [63:0] DS = 64'((2 * k + 2) * (2 * k + 3));
        localparam bit MINUS = (k % 2) == 0;
        logic               mv;
        logic [63:0]        mc, ms;
        logic [SW_S-1:0]    mside;
        logic [63:0]        tcn, tsn;
        logic signed [63:0] scm, ssm;
        logic [63:0]        tc_reg, ts_reg, x2_reg;
        logic signed [63:0] sc_reg, ss_reg;
        logic [SW_A-1:0]    a_reg;
        logic               v_reg;

        bmg_mulq #(.SIDE_W(SW_S)) u_cmul (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v_w[k]),
            .a        (tc_w[k]),
            .b        (x2_w[k]),
            .side_in  ({sc_w[k], ss_w[k], x2_w[k], a_w[k]}),
            .out_valid(mv),
            .p        (mc),
            .side_out (mside)
        );

        bmg_mulq #(.SIDE_W(1)) u_smul (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v_w[k]),
            .a        (ts_w[k]),
            .b        (x2_w[k]),
            .side_in  (1'b0),
            .out_valid(),
            .p        (ms),
            .side_out ()
        );

        assign tcn = mc / DC;
        assign tsn = ms / DS;
        assign scm = $signed(mside[SW_S-1:SW_S-64]);
        assign ssm = $signed(mside[SW_S-65:SW_S-128]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= mv;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tc_reg <= tcn;
                ts_reg <= tsn;
                sc_reg <= MINUS ? scm - $signed(tcn) : scm + $signed(tcn);
                ss_reg <= MINUS ? ssm - $signed(tsn) : ssm + $signed(tsn);
                x2_reg <= mside[SW_S-129:SW_A];
                a_reg  <= mside[SW_A-1:0];
            end
        end

        assign tc_w[k+1] = tc_reg;
        assign ts_w[k+1] = ts_reg;
        assign sc_w[k+1] = sc_reg;
        assign ss_w[k+1] = ss_reg;
        assign x2_w[k+1] = x2_reg;
        assign a_w[k+1]  = a_reg;
        assign v_w[k+1]  = v_reg;
    end

    logic [SW_A-1:0]   af;
    logic [63:0]       cm_reg;
    logic              cn_reg;
    logic [SIDE_W-1:0] cs_reg;
    logic              cv_reg;

    assign af = a_w[TRIG_TERMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg <= 1'b0;
        else if (en)
            cv_reg <= v_w[TRIG_TERMS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_reg <= af[SW_A-1] ? 64'(sc_w[TRIG_TERMS]) : 64'(ss_w[TRIG_TERMS]);
            cn_reg <= af[SW_A-2];
            cs_reg <= af[SIDE_W-1:0];
        end
    end

    assign out_valid = cv_reg;
    assign cmag      = cm_reg;
    assign cneg      = cn_reg;
    assign side_out  = cs_reg;

endmodule

>>> design/bmg_scale.sv
// ----------------------------------------------------------------------------
// bmg_scale
// Output path: r*|cos|, sigma scaling with rounding, mean offset, saturation.
// ----------------------------------------------------------------------------
module bmg_scale
    import bmg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [63:0]        r,
    input  logic [63:0]        cmag,
    input  logic               cneg,
    input  cfg_t               cfg,
    output logic               out_valid,
    output logic signed [31:0] sample,
    output logic               clipped
);

    logic        mv;
    logic [63:0] mag;
    logic        mneg;

    bmg_mulq #(.SIDE_W(1)) u_rmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .a        (r),
        .b        (cmag),
        .side_in  (cneg),
        .out_valid(mv),
        .p        (mag),
        .side_out (mneg)
    );

    logic [63:0] plo_reg, phi_reg;
    logic        pn_reg, pv_reg;
    logic [95:0] full;
    logic [39:0] prod_reg;
    logic        qn_reg, qv_reg;

    assign full = {phi_reg, 32'd0} + {32'd0, plo_reg} + {32'd0, HALF_LSB_W};

    logic signed [41:0] mean_x, prod_x, total;

    assign mean_x = {{10{cfg.mean[31]}}, cfg.mean};
    assign prod_x = {2'b00, prod_reg};
    assign total  = qn_reg ? mean_x - prod_x : mean_x + prod_x;

    logic signed [31:0] smp_reg;
    logic               clp_reg, ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            qv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= mv;
            qv_reg <= pv_reg;
            ov_reg <= qv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg  <= 64'(cfg.sigma) * 64'(mag[31:0]);
            phi_reg  <= 64'(cfg.sigma) * 64'(mag[63:32]);
            pn_reg   <= mneg;
            prod_reg <= full[95:WF];
            qn_reg   <= pn_reg;
            if (total > 42'sd2147483647)
            begin
                smp_reg <= 32'sh7FFFFFFF;
                clp_reg <= 1'b1;
            end
            else if (total < -42'sd2147483648)
            begin
                smp_reg <= 32'sh80000000;
                clp_reg <= 1'b1;
            end
            else
            begin
                smp_reg <= total[31:0];
                clp_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign sample    = smp_reg;
    assign clipped   = clp_reg;

endmodule

>>> design/box_muller_gaussian.sv
// ----------------------------------------------------------------------------
// box_muller_gaussian
// Box-Muller gaussian generator: mean + sigma*sqrt(-2 ln u0)*cos(2 pi u1).
//
//   Channel   Dir  Payload                         Handshake
//   uniform   in   u_radius, u_angle               valid/ready
//   gauss     out  sample (Q16.16), clipped        valid/ready
//   apb       in   mean @0x0, sigma @0x4           psel/penable, pready=1
//
// One request enters per cycle unless the output stalls. The radius path is
// deepest: 56-stage log divider, 20 atanh terms, 8 Newton steps of 61 stages.
// Reset clears all valid bits and loads mean 0, sigma 1.0.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module box_muller_gaussian
    import bmg_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    bmg_uniform_if.sink         uniform,
    bmg_gauss_if.source         gauss,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    cfg_t     cfg_reg;
    reg_idx_t widx;
    logic     en;

    assign widx   = reg_idx_t'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mean  <= MEAN_RESET;
            cfg_reg.sigma <= SIGMA_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (widx)
                REG_MEAN:  cfg_reg.mean  <= pwdata;
                REG_SIGMA: cfg_reg.sigma <= pwdata;
                default:   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_MEAN:  prdata = cfg_reg.mean;
            REG_SIGMA: prdata = cfg_reg.sigma;
            default:   prdata = '0;
        endcase
    end

    // advance unless the output request is held
    assign en            = !(gauss.valid && !gauss.ready);
    assign uniform.ready = en;

    logic                    rv;
    logic [63:0]             rr;
    logic [UNIFORM_BITS-1:0] rang;

    bmg_radius #(.UB(UNIFORM_BITS), .SIDE_W(UNIFORM_BITS)) u_radius (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (uniform.valid),
        .k0       (uniform.u_radius),
        .side_in  (uniform.u_angle),
        .out_valid(rv),
        .r        (rr),
        .side_out (rang)
    );

    logic [WF-1:0] turn;
    logic          cv;
    logic [63:0]   cm;
    logic          cn;
    logic [63:0]   cr;

    assign turn = WF'(rang) << (WF - UNIFORM_BITS);

    bmg_cosine #(.SIDE_W(64)) u_cosine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (rv),
        .turn     (turn),
        .side_in  (rr),
        .out_valid(cv),
        .cmag     (cm),
        .cneg     (cn),
        .side_out (cr)
    );

    bmg_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cv),
        .r        (cr),
        .cmag     (cm),
        .cneg     (cn),
        .cfg      (cfg_reg),
        .out_valid(gauss.valid),
        .sample   (gauss.sample),
        .clipped  (gauss.clipped)
    );

endmodule

>>> design/bmg_checker.sv
// ----------------------------------------------------------------------------
// bmg_checker
// Port-level checks of the gaussian generator, bound to the top level.
// ----------------------------------------------------------------------------
module bmg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] sample,
    input logic               clipped
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(clipped))
        else $error("held result changed");

    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while output stalled");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (sample == 32'sh7FFFFFFF) || (sample == 32'sh80000000))
        else $error("clipped sample not at a rail");

    a_rst: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind box_muller_gaussian bmg_checker u_bmg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (uniform.valid),
    .in_ready (uniform.ready),
    .out_valid(gauss.valid),
    .out_ready(gauss.ready),
    .sample   (gauss.sample),
    .clipped  (gauss.clipped)
);
